// ===== src/nsti_pkg.sv =====
// Package: shared constants, codes, types and helpers for the node set to tour interval block.
package nsti_pkg;

    localparam int NODES     = 64;
    localparam int POSITIONS = 64;
    localparam int FW        = 2;
    localparam int NW        = 6;
    localparam int PW        = 6;

    // Only the first 64 nodes can be named by a 6-bit node field.
    localparam int TBL_DEPTH = (NODES < 64) ? NODES : 64;
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    typedef enum logic [FW-1:0] {
        FN_LOAD   = 2'd0,
        FN_MEMBER = 2'd1,
        FN_END    = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MARK,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic mark;
        logic scan_start;
        logic scan_step;
    } t_scan_ctl;

    function automatic logic node_in_range(input logic [NW-1:0] node);
        return ({2'b00, node} < 8'(NODES));
    endfunction

endpackage

// ===== src/nsti_tbl.sv =====
// Node to tour position table: one write port, one registered read port.
module nsti_tbl (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [nsti_pkg::TBL_AW-1:0]   i_wr_addr,
    input  logic [nsti_pkg::PW-1:0]       i_wr_data,
    input  logic                          i_rd_en,
    input  logic [nsti_pkg::TBL_AW-1:0]   i_rd_addr,
    output logic [nsti_pkg::PW-1:0]       o_rd_data
);

    logic [nsti_pkg::PW-1:0] r_mem [nsti_pkg::TBL_DEPTH];
    logic [nsti_pkg::PW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/nsti_scan.sv =====
// Position bitmap with a one-position-per-cycle run scanner and registered result.
module nsti_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  nsti_pkg::t_scan_ctl       i_ctl,
    input  logic [nsti_pkg::PW-1:0]   i_mark_pos,
    output logic                      o_done,
    output logic                      o_valid,
    output logic [nsti_pkg::PW-1:0]   o_start_pos,
    output logic [nsti_pkg::PW-1:0]   o_end_pos,
    output logic                      o_last,
    output logic                      o_empty_res
);

    logic [nsti_pkg::POSITIONS-1:0] r_map, n_map;
    logic [nsti_pkg::PW-1:0]        r_pos, n_pos;
    logic                           r_open, n_open;
    logic [nsti_pkg::PW-1:0]        r_start, n_start;
    logic                           r_valid, n_valid;
    logic [nsti_pkg::PW-1:0]        r_start_pos, n_start_pos;
    logic [nsti_pkg::PW-1:0]        r_end_pos, n_end_pos;
    logic                           r_last, n_last;
    logic                           r_empty_res, n_empty_res;

    logic [nsti_pkg::POSITIONS-1:0] map_cleared;
    logic                           bit_cur;
    logic                           bit_nxt;
    logic                           map_empty;
    logic                           emit_run;

    always_comb begin
        map_cleared = r_map & ~(nsti_pkg::POSITIONS'(1) << r_pos);
        bit_cur     = r_map[r_pos];
        bit_nxt     = (r_pos != nsti_pkg::PW'(nsti_pkg::POSITIONS - 1))
                      && r_map[r_pos + nsti_pkg::PW'(1)];
        map_empty   = (r_map == '0);
        emit_run    = i_ctl.scan_step && bit_cur && !bit_nxt;
        o_done      = i_ctl.scan_step && (map_empty || (emit_run && map_cleared == '0));
    end

    always_comb begin
        n_map       = r_map;
        n_pos       = r_pos;
        n_open      = r_open;
        n_start     = r_start;
        n_valid     = 1'b0;
        n_start_pos = r_start_pos;
        n_end_pos   = r_end_pos;
        n_last      = r_last;
        n_empty_res = r_empty_res;

        if (i_ctl.mark) begin
            n_map = r_map | (nsti_pkg::POSITIONS'(1) << i_mark_pos);
        end

        if (i_ctl.scan_start) begin
            n_pos  = '0;
            n_open = 1'b0;
        end

        if (i_ctl.scan_step) begin
            // clear each position as it is passed, so the map ends empty
            n_map = map_cleared;
            n_pos = r_pos + nsti_pkg::PW'(1);
            if (map_empty) begin
                n_valid     = 1'b1;
                n_start_pos = '0;
                n_end_pos   = '0;
                n_last      = 1'b1;
                n_empty_res = 1'b1;
            end else if (emit_run) begin
                n_valid     = 1'b1;
                n_start_pos = r_open ? r_start : r_pos;
                n_end_pos   = r_pos;
                n_last      = (map_cleared == '0);
                n_empty_res = 1'b0;
                n_open      = 1'b0;
            end else if (bit_cur && !r_open) begin
                n_open  = 1'b1;
                n_start = r_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_pos   <= '0;
            r_open  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_map   <= n_map;
            r_pos   <= n_pos;
            r_open  <= n_open;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start     <= n_start;
        r_start_pos <= n_start_pos;
        r_end_pos   <= n_end_pos;
        r_last      <= n_last;
        r_empty_res <= n_empty_res;
    end

    assign o_valid     = r_valid;
    assign o_start_pos = r_start_pos;
    assign o_end_pos   = r_end_pos;
    assign o_last      = r_last;
    assign o_empty_res = r_empty_res;

    a_last_clears_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_map == '0))
        else $error("bitmap not empty after final item");

    a_no_open_run_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> !r_open)
        else $error("run still open after final item");

endmodule

// ===== src/node_set_to_tour_intervals.sv =====
// Top level: command sequencer tying the position table to the run scanner.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  input    | start, busy        | i_func, i_node, i_position
//  result   | o_valid (strobe)   | o_start_pos, o_end_pos, o_last, o_empty_res
//
// Load item: table write. Member item: table read, then bitmap mark.
// End item: the scanner walks the bitmap one position per cycle and stops after the last run,
// or at its first step with an empty result when no position is marked.
// Each result shows on the ports for one cycle, in the cycle after its scan step.
// Reset clears the bitmap and the sequencer; table entries stay unknown until loaded.
// The receiver cannot stall; results are never held back.
module node_set_to_tour_intervals (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [nsti_pkg::FW-1:0]    i_func,
    input  logic [nsti_pkg::NW-1:0]    i_node,
    input  logic [nsti_pkg::PW-1:0]    i_position,
    output logic                       o_valid,
    output logic [nsti_pkg::PW-1:0]    o_start_pos,
    output logic [nsti_pkg::PW-1:0]    o_end_pos,
    output logic                       o_last,
    output logic                       o_empty_res
);

    nsti_pkg::t_state    r_state, n_state;
    nsti_pkg::t_scan_ctl scan_ctl;

    logic                       accept;
    logic                       in_range;
    logic                       tbl_wr_en;
    logic                       tbl_rd_en;
    logic [nsti_pkg::PW-1:0]    tbl_rd_data;
    logic                       scan_done;

    assign accept   = start && !busy;
    assign in_range = nsti_pkg::node_in_range(i_node);

    always_comb begin
        n_state = r_state;
        case (r_state)
            nsti_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_func)
                        nsti_pkg::FN_MEMBER: n_state = in_range ? nsti_pkg::S_MARK
                                                                : nsti_pkg::S_IDLE;
                        nsti_pkg::FN_END:    n_state = nsti_pkg::S_SCAN;
                        default:             n_state = nsti_pkg::S_IDLE;
                    endcase
                end
            end
            nsti_pkg::S_MARK: n_state = nsti_pkg::S_IDLE;
            nsti_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = nsti_pkg::S_IDLE;
                end
            end
            default: n_state = nsti_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        busy                = (r_state != nsti_pkg::S_IDLE);
        tbl_wr_en           = accept && (i_func == nsti_pkg::FN_LOAD) && in_range;
        tbl_rd_en           = accept && (i_func == nsti_pkg::FN_MEMBER);
        scan_ctl.mark       = (r_state == nsti_pkg::S_MARK);
        scan_ctl.scan_start = accept && (i_func == nsti_pkg::FN_END);
        scan_ctl.scan_step  = (r_state == nsti_pkg::S_SCAN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsti_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    nsti_tbl u_tbl (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (i_node[nsti_pkg::TBL_AW-1:0]),
        .i_wr_data (i_position),
        .i_rd_en   (tbl_rd_en),
        .i_rd_addr (i_node[nsti_pkg::TBL_AW-1:0]),
        .o_rd_data (tbl_rd_data)
    );

    nsti_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_mark_pos  (tbl_rd_data),
        .o_done      (scan_done),
        .o_valid     (o_valid),
        .o_start_pos (o_start_pos),
        .o_end_pos   (o_end_pos),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == nsti_pkg::S_SCAN))
        else $error("result strobe outside a scan");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_res) |-> o_last)
        else $error("empty result not flagged last");

    a_run_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_empty_res) |-> (o_start_pos <= o_end_pos))
        else $error("run start beyond run end");

endmodule
